// ===== hw/rtl/frustum_sphere_box_cull_unit_assert.svh =====
// Assertion macros for the frustum cull unit.
// No dependencies; included by the top level.
`ifndef FRUSTUM_SPHERE_BOX_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_SPHERE_BOX_CULL_UNIT_ASSERT_SVH

// Expression must hold at every edge out of reset.
`define FSCU_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fscu_pkg.sv =====
// Types and codes shared by the frustum cull unit.
// No dependencies.
`timescale 1ns / 1ps

package fscu_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_VERTEX = 2'd2,
    CMD_FIGURE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [2:0]         plane_index;
    logic signed [15:0] normal_a;
    logic signed [15:0] normal_b;
    logic signed [15:0] normal_c;
    logic signed [31:0] offset_d;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [30:0]        radius;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic visible;
    logic fully_inside;
  } out_item_t;

  // Item traveling along the cell row.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } tok_t;

  // Running verdict handed from cell to cell, in the cycle after the item.
  typedef struct packed {
    logic valid;
    cmd_t command;
    logic last_point;
    logic ok;       // sphere pass / box still visible
    logic outside;  // some vertex behind some plane
  } res_t;

  localparam int DIST_W = 52;  // distance in Q.30, plus headroom

endpackage

// ===== hw/rtl/frustum_sphere_box_cull_unit.sv =====
// Frustum cull unit: a row of NUM_PLANES plane cells, one plane per cell.
// Items pass each cell's stage 1 register, then the last verdict and output registers.
// One item per cycle unless stalled; each cell has a two-stage multiply/sum pipeline.
// A stalled output register freezes the whole row, and in_stall follows it.
// Reset (rst_n low, synchronous) empties the row, clears the per-plane vertex flags
// and the outside flag, and sets the held sphere verdict; planes stay undefined.
`timescale 1ns / 1ps
`include "frustum_sphere_box_cull_unit_assert.svh"

module frustum_sphere_box_cull_unit import fscu_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Row wiring: tok_chain[i] feeds cell i, res_chain[i] is its incoming verdict.
  tok_t tok_chain [NUM_PLANES];
  res_t res_chain [NUM_PLANES+1];

  logic      en;
  res_t      fin;
  logic      box_done;
  logic      outside_all;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      some_out_r, some_out_nxt;  // a vertex of the current box was behind a plane
  logic      held_r, held_nxt;          // figure-mode sphere verdict

  // Row advances unless a finished result sits unread.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign tok_chain[0] = '{valid: in_valid, item: in_item};
  assign res_chain[0] = '{valid: 1'b0, command: CMD_LOAD, last_point: 1'b0,
                          ok: 1'b1, outside: 1'b0};

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    if (i < NUM_PLANES - 1) begin : g_mid
      fscu_cell #(.CELL_IDX(i)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tok_in  (tok_chain[i]),
        .acc_in  (res_chain[i]),
        .tok_out (tok_chain[i+1]),
        .res_out (res_chain[i+1])
      );
    end else begin : g_last
      // last cell: the item itself goes no further, only its verdict
      fscu_cell #(.CELL_IDX(i)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tok_in  (tok_chain[i]),
        .acc_in  (res_chain[i]),
        .tok_out (),
        .res_out (res_chain[i+1])
      );
    end
  end

  // Verdict leaving the row, one per item.
  assign fin         = res_chain[NUM_PLANES];
  assign outside_all = some_out_r || fin.outside;
  assign box_done    = en && fin.valid && (fin.command == CMD_VERTEX) && fin.last_point;

  // Finish stage: sphere results, figure hold, box accumulation and result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    some_out_nxt  = some_out_r;
    held_nxt      = held_r;
    if (en) begin
      out_valid_nxt = 1'b0;
      if (fin.valid) begin
        case (fin.command)
          CMD_SPHERE: begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{visible: fin.ok, fully_inside: 1'b0};
          end
          CMD_FIGURE: begin
            held_nxt = fin.ok;
          end
          CMD_VERTEX: begin
            if (fin.last_point) begin
              out_valid_nxt = 1'b1;
              out_item_nxt.visible      = held_r && fin.ok;
              out_item_nxt.fully_inside = held_r && fin.ok && !outside_all;
              some_out_nxt  = 1'b0;
              held_nxt      = 1'b1;
            end else begin
              some_out_nxt = outside_all;
            end
          end
          default: begin
            // plane load: written inside its cell, nothing to report
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      some_out_r  <= 1'b0;
      held_r      <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      some_out_r  <= some_out_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // fully inside is only ever reported for a visible volume
  `FSCU_ASSERT_ALWAYS(a_inside_implies_visible, clk, rst_n,
    !out_valid_r || out_item_r.visible || !out_item_r.fully_inside,
    "fully_inside set on a culled volume")

  // a finished box leaves no figure verdict and no outside flag behind
  `FSCU_ASSERT_NEXT(a_box_end_clears, clk, rst_n, box_done,
    held_r && !some_out_r,
    "box state not cleared after final vertex")

  // a held result freezes the row
  `FSCU_ASSERT_NEXT(a_row_frozen, clk, rst_n, in_stall,
    $stable(res_chain[NUM_PLANES]) && $stable(held_r) && $stable(some_out_r),
    "cell row moved while output stalled")

endmodule

// ===== hw/rtl/fscu_cell.sv =====
// One plane cell: holds a plane, multiplies in stage 1, sums and tests in stage 2.
// Depends on fscu_pkg.
`timescale 1ns / 1ps

module fscu_cell import fscu_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  tok_t tok_in,
  input  res_t acc_in,
  output tok_t tok_out,
  output res_t res_out
);

  // plane store, undefined until loaded
  logic signed [15:0] na_r, nb_r, nc_r;
  logic signed [31:0] d_r;

  logic               tok_vld_r;
  in_item_t           item_r;
  logic signed [47:0] px_r, py_r, pz_r;
  logic signed [32:0] bias_r;
  logic               has_r, has_nxt;
  logic               res_vld_r;
  res_t               res_r, res_nxt;

  logic               load_hit;
  logic               sph_in;
  logic signed [47:0] px_nxt, py_nxt, pz_nxt;
  logic signed [32:0] bias_nxt;
  logic signed [DIST_W-1:0] dist_sum;
  logic               behind;
  logic               has_now;

  // stage 1: products against the stored plane
  assign load_hit = tok_in.valid && (tok_in.item.command == CMD_LOAD) &&
                    ({2'b00, tok_in.item.plane_index} == 5'(CELL_IDX));
  assign sph_in   = (tok_in.item.command == CMD_SPHERE) ||
                    (tok_in.item.command == CMD_FIGURE);
  assign px_nxt   = na_r * tok_in.item.point_x;
  assign py_nxt   = nb_r * tok_in.item.point_y;
  assign pz_nxt   = nc_r * tok_in.item.point_z;
  assign bias_nxt = 33'(d_r) +
                    (sph_in ? $signed({2'b00, tok_in.item.radius}) : 33'sd0);

  // stage 2: distance (plus radius for spheres) and sign test
  assign dist_sum = DIST_W'(px_r) + DIST_W'(py_r) + DIST_W'(pz_r) +
                    (DIST_W'(bias_r) <<< 14);
  assign behind   = dist_sum[DIST_W-1];
  assign has_now  = has_r || !behind;

  always_comb begin
    res_nxt            = acc_in;
    res_nxt.valid      = tok_vld_r;
    res_nxt.command    = item_r.command;
    res_nxt.last_point = item_r.last_point;
    has_nxt            = has_r;
    case (item_r.command)
      CMD_SPHERE, CMD_FIGURE: begin
        res_nxt.ok = acc_in.ok && !behind;
      end
      CMD_VERTEX: begin
        res_nxt.ok      = acc_in.ok && has_now;
        res_nxt.outside = acc_in.outside || behind;
        if (tok_vld_r) begin
          has_nxt = item_r.last_point ? 1'b0 : has_now;
        end
      end
      default: begin
        res_nxt.ok = acc_in.ok;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      has_r     <= 1'b0;
    end else if (en) begin
      tok_vld_r <= tok_in.valid;
      res_vld_r <= res_nxt.valid;
      has_r     <= has_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= tok_in.item;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      bias_r <= bias_nxt;
      res_r  <= res_nxt;
      if (load_hit) begin
        na_r <= tok_in.item.normal_a;
        nb_r <= tok_in.item.normal_b;
        nc_r <= tok_in.item.normal_c;
        d_r  <= tok_in.item.offset_d;
      end
    end
  end

  always_comb begin
    tok_out       = '{valid: tok_vld_r, item: item_r};
    res_out       = res_r;
    res_out.valid = res_vld_r;
  end

endmodule
